>>> hdl/show_control_message_parser_assert.svh
// Assertion macros for the show-control message parser
`ifndef SHOW_CONTROL_MESSAGE_PARSER_ASSERT_SVH
`define SHOW_CONTROL_MESSAGE_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define SCP_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SCP_ASSERT_IMP(lbl, clk, rstn, a, c)
`define SCP_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

>>> hdl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Types and constants shared by the show-control parser modules.
// ----------------------------------------------------------------------------
package scp_pkg;
  localparam int CUE_VALUE_WIDTH_DEF = 32;
  localparam logic [7:0] BYTE_SOX = 8'hF0;
  localparam logic [7:0] BYTE_EOX = 8'hF7;
  localparam logic [7:0] BYTE_SUB = 8'h7F;
  localparam logic [7:0] BYTE_MSC = 8'h02;
  localparam logic [7:0] BYTE_DOT = 8'h2E;
  localparam logic [7:0] BYTE_ZERO = 8'h30;
  localparam logic [7:0] BYTE_NINE = 8'h39;
  localparam logic [7:0] CMD_TIMED_GO = 8'h04;
  localparam logic [7:0] CMD_SET = 8'h06;
  localparam logic [7:0] CMD_FIRE = 8'h07;
  localparam logic [7:0] CMD_GO_LIGHT = 8'h18;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0, KIND_TIME = 3'd1, KIND_CUE_NUM = 3'd2, KIND_CUE_LIST = 3'd3,
    KIND_CUE_PATH = 3'd4, KIND_CONTROL = 3'd5, KIND_MACRO = 3'd6
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t        kind;
    logic         ok;
    logic [1:0]   count;
    logic [39:0]  first;
    logic [31:0]  second;
    logic [31:0]  third;
    logic         last;
  } item_t;

  // finished message snapshot handed from parser to emitter
  typedef struct packed {
    logic         ok;
    logic [7:0]   dev;
    logic [7:0]   fmt;
    logic [7:0]   cmd;
    logic [39:0]  tbytes;
    logic [3:0]   pres;
    logic [1:0]   cnt1;
    logic [1:0]   cnt2;
    logic [1:0]   cnt3;
    logic [31:0]  c0, c1, c2, c3, c4, c5, c6, c7, c8;
    logic [27:0]  ctrl;
    logic [7:0]   macro;
  } msg_t;
endpackage

>>> hdl/scp_front.sv
// ----------------------------------------------------------------------------
// scp_front
// Byte parser: walks the header and body, raises a message snapshot at 0xF7.
// ----------------------------------------------------------------------------
module scp_front import scp_pkg::*; #(
  parameter int CUE_VALUE_WIDTH = CUE_VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] rx_byte,
  output logic       msg_vld,
  output msg_t       msg
);
  typedef enum logic [4:0] {
    PH_IDLE, PH_SUB, PH_DEV, PH_SUB2, PH_FMT, PH_CMD, PH_T0, PH_T1, PH_T2, PH_T3,
    PH_T4, PH_SET0, PH_SET1, PH_SET2, PH_SET3, PH_SETOPT, PH_FIRE, PH_OPTLIST,
    PH_CUE, PH_DONE
  } phase_t;

  localparam logic [31:0] CMASK = 32'hFFFF_FFFF >> (32 - CUE_VALUE_WIDTH);

  phase_t      ph_r, ph_nxt;
  logic [7:0]  dev_r, dev_nxt, fmt_r, fmt_nxt, cmd_r, cmd_nxt;
  logic [39:0] tb_r, tb_nxt;
  logic [31:0] comp_r [9];
  logic [31:0] comp_nxt [9];
  logic [1:0]  cnt_r [3];
  logic [1:0]  cnt_nxt [3];
  logic [3:0]  pres_r, pres_nxt;
  logic [27:0] ctrl_r, ctrl_nxt;
  logic [7:0]  mac_r, mac_nxt;
  logic        err_r, err_nxt;
  logic [1:0]  base_r, base_nxt, max_r, max_nxt, begun_r, begun_nxt;
  logic        req_r, req_nxt, open_r, open_nxt, skip_r, skip_nxt;
  logic        msg_vld_nxt, ok_w;
  logic [2:0]  slot;
  logic [1:0]  cc;
  logic [3:0]  idx;
  logic [2:0]  ti;
  logic        go_cue;

  always_comb begin
    ph_nxt = ph_r; dev_nxt = dev_r; fmt_nxt = fmt_r; cmd_nxt = cmd_r; tb_nxt = tb_r;
    comp_nxt = comp_r; cnt_nxt = cnt_r; pres_nxt = pres_r; ctrl_nxt = ctrl_r;
    mac_nxt = mac_r; err_nxt = err_r; base_nxt = base_r; max_nxt = max_r;
    begun_nxt = begun_r; req_nxt = req_r; open_nxt = open_r; skip_nxt = skip_r;
    msg_vld_nxt = 1'b0; slot = '0; cc = '0; idx = '0; ti = '0; go_cue = 1'b0;
    ok_w = !err_r;
    if (ph_r < PH_SETOPT || ph_r == PH_FIRE) ok_w = 1'b0;
    if (ph_r == PH_CUE && req_r && begun_r == 2'd0) ok_w = 1'b0;
    if (byte_vld) begin
      if (rx_byte == BYTE_SOX) begin
        ph_nxt = PH_SUB; dev_nxt = '0; fmt_nxt = '0; cmd_nxt = '0; tb_nxt = '0;
        for (int i = 0; i < 9; i++) comp_nxt[i] = '0;
        for (int i = 0; i < 3; i++) cnt_nxt[i] = '0;
        pres_nxt = '0; ctrl_nxt = '0; mac_nxt = '0; err_nxt = 1'b0;
        base_nxt = '0; max_nxt = '0; begun_nxt = '0;
        req_nxt = 1'b0; open_nxt = 1'b0; skip_nxt = 1'b0;
      end else if (rx_byte == BYTE_EOX) begin
        if (ph_r != PH_IDLE) begin
          msg_vld_nxt = 1'b1; ph_nxt = PH_IDLE;
        end
      end else begin
        unique case (ph_r)
          PH_SUB: begin
            if (rx_byte != BYTE_SUB) begin err_nxt = 1'b1; ph_nxt = PH_DONE; end
            else ph_nxt = PH_DEV;
          end
          PH_DEV: begin dev_nxt = rx_byte; ph_nxt = PH_SUB2; end
          PH_SUB2: begin
            if (rx_byte != BYTE_MSC) begin err_nxt = 1'b1; ph_nxt = PH_DONE; end
            else ph_nxt = PH_FMT;
          end
          PH_FMT: begin fmt_nxt = rx_byte; ph_nxt = PH_CMD; end
          PH_CMD: begin
            cmd_nxt = rx_byte;
            unique case (rx_byte)
              8'h01, 8'h02, 8'h03, 8'h05, 8'h0B, 8'h10: begin
                base_nxt = 2'd1; max_nxt = 2'd3; req_nxt = 1'b0; ph_nxt = PH_CUE;
              end
              8'h04, 8'h18: ph_nxt = PH_T0;
              8'h06: ph_nxt = PH_SET0;
              8'h07: ph_nxt = PH_FIRE;
              8'h08, 8'h09, 8'h0A: ph_nxt = PH_DONE;
              8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h19, 8'h1A:
                ph_nxt = PH_OPTLIST;
              8'h1B, 8'h1C: begin
                base_nxt = 2'd2; max_nxt = 2'd1; req_nxt = 1'b1; ph_nxt = PH_CUE;
              end
              8'h1D, 8'h1E: begin
                base_nxt = 2'd3; max_nxt = 2'd1; req_nxt = 1'b1; ph_nxt = PH_CUE;
              end
              default: begin err_nxt = 1'b1; ph_nxt = PH_DONE; end
            endcase
          end
          PH_SETOPT, PH_T0, PH_T1, PH_T2, PH_T3, PH_T4: begin
            ti = (ph_r == PH_SETOPT) ? 3'd0 : 3'(ph_r - PH_T0);
            unique case (ti)
              3'd0: tb_nxt[39:32] = tb_r[39:32] | rx_byte;
              3'd1: tb_nxt[31:24] = tb_r[31:24] | rx_byte;
              3'd2: tb_nxt[23:16] = tb_r[23:16] | rx_byte;
              3'd3: tb_nxt[15:8]  = tb_r[15:8]  | rx_byte;
              default: tb_nxt[7:0] = tb_r[7:0] | rx_byte;
            endcase
            if (ti < 3'd4) ph_nxt = phase_t'(PH_T0 + 5'(ti) + 5'd1);
            else begin
              pres_nxt[0] = 1'b1;
              if (cmd_r == CMD_TIMED_GO) begin
                base_nxt = 2'd1; max_nxt = 2'd3; req_nxt = 1'b0; ph_nxt = PH_CUE;
                begun_nxt = '0; open_nxt = 1'b0; skip_nxt = 1'b0;
              end else if (cmd_r == CMD_GO_LIGHT) ph_nxt = PH_OPTLIST;
              else ph_nxt = PH_DONE;
            end
          end
          PH_SET0: begin ctrl_nxt[20:14] = rx_byte[6:0]; ph_nxt = PH_SET1; end
          PH_SET1: begin ctrl_nxt[27:21] = rx_byte[6:0]; ph_nxt = PH_SET2; end
          PH_SET2: begin ctrl_nxt[6:0] = rx_byte[6:0]; ph_nxt = PH_SET3; end
          PH_SET3: begin ctrl_nxt[13:7] = rx_byte[6:0]; ph_nxt = PH_SETOPT; end
          PH_FIRE: begin mac_nxt = rx_byte; ph_nxt = PH_DONE; end
          PH_OPTLIST: begin
            if (rx_byte == 8'h00) ph_nxt = PH_DONE;
            else begin
              base_nxt = 2'd2; max_nxt = 2'd1; req_nxt = 1'b0; ph_nxt = PH_CUE;
              begun_nxt = '0; open_nxt = 1'b0; skip_nxt = 1'b0;
              go_cue = 1'b1;
            end
          end
          PH_CUE: go_cue = 1'b1;
          default: ;
        endcase
        // cue text; works on the _nxt view so that the option-list entry chains
        if (go_cue) begin
          if (!open_nxt) begin
            if (rx_byte == 8'h00 && begun_nxt != 2'd0) go_cue = 1'b0;
            else if (begun_nxt >= max_nxt) begin ph_nxt = PH_DONE; go_cue = 1'b0; end
            else begin
              slot = 3'(base_nxt) + 3'(begun_nxt);
              if (slot < 3'd1 || slot > 3'd3) begin ph_nxt = PH_DONE; go_cue = 1'b0; end
              else begin
                begun_nxt = begun_nxt + 2'd1; open_nxt = 1'b1; skip_nxt = 1'b0;
                cnt_nxt[slot[1:0] - 2'd1] = 2'd1;
                pres_nxt[slot[1:0]] = 1'b1;
              end
            end
          end
          if (go_cue) begin
            slot = 3'(base_nxt) + 3'(begun_nxt) - 3'd1;
            if (slot >= 3'd1 && slot <= 3'd3) begin
              cc = cnt_nxt[slot[1:0] - 2'd1];
              if (rx_byte == 8'h00) open_nxt = 1'b0;
              else if (!skip_nxt) begin
                if (rx_byte == BYTE_DOT) begin
                  if (cc < 2'd3) cnt_nxt[slot[1:0] - 2'd1] = cc + 2'd1;
                  else skip_nxt = 1'b1;
                end else if (rx_byte >= BYTE_ZERO && rx_byte <= BYTE_NINE && cc != 2'd0) begin
                  idx = 4'((slot - 3'd1) * 3'd3) + 4'(cc) - 4'd1;
                  comp_nxt[idx] = ((comp_nxt[idx] << 3) + (comp_nxt[idx] << 1)
                                  + 32'(rx_byte - BYTE_ZERO)) & CMASK;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; dev_r <= '0; fmt_r <= '0; cmd_r <= '0; tb_r <= '0;
      for (int i = 0; i < 9; i++) comp_r[i] <= '0;
      for (int i = 0; i < 3; i++) cnt_r[i] <= '0;
      pres_r <= '0; ctrl_r <= '0; mac_r <= '0; err_r <= 1'b0;
      base_r <= '0; max_r <= '0; begun_r <= '0;
      req_r <= 1'b0; open_r <= 1'b0; skip_r <= 1'b0; msg_vld <= 1'b0;
    end else begin
      ph_r <= ph_nxt; dev_r <= dev_nxt; fmt_r <= fmt_nxt; cmd_r <= cmd_nxt;
      tb_r <= tb_nxt; comp_r <= comp_nxt; cnt_r <= cnt_nxt; pres_r <= pres_nxt;
      ctrl_r <= ctrl_nxt; mac_r <= mac_nxt; err_r <= err_nxt; base_r <= base_nxt;
      max_r <= max_nxt; begun_r <= begun_nxt; req_r <= req_nxt; open_r <= open_nxt;
      skip_r <= skip_nxt; msg_vld <= msg_vld_nxt;
    end
  end

  // snapshot taken with the closing byte
  always_ff @(posedge clk) begin
    if (msg_vld_nxt) begin
      msg.ok <= ok_w; msg.dev <= dev_r; msg.fmt <= fmt_r; msg.cmd <= cmd_r;
      msg.tbytes <= tb_r; msg.pres <= pres_r;
      msg.cnt1 <= cnt_r[0]; msg.cnt2 <= cnt_r[1]; msg.cnt3 <= cnt_r[2];
      msg.c0 <= comp_r[0]; msg.c1 <= comp_r[1]; msg.c2 <= comp_r[2];
      msg.c3 <= comp_r[3]; msg.c4 <= comp_r[4]; msg.c5 <= comp_r[5];
      msg.c6 <= comp_r[6]; msg.c7 <= comp_r[7]; msg.c8 <= comp_r[8];
      msg.ctrl <= ctrl_r; msg.macro <= mac_r;
    end
  end
endmodule

>>> hdl/scp_back.sv
// ----------------------------------------------------------------------------
// scp_back
// Message queue and item emitter: turns each snapshot into its run of items.
// ----------------------------------------------------------------------------
module scp_back import scp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  msg_vld,
  input  msg_t  msg,
  output logic  q_full,
  output logic  out_vld,
  output item_t out_item,
  input  logic  out_take
);
  // message queue; a message is 2+ bytes, and q_full holds off input when the slots are taken
  msg_t       q_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic [2:0] step_r;
  msg_t       m;
  item_t      it;
  logic       have, done, take;

  assign m = q_r[rp_r];
  assign have = cnt_r != 2'd0;
  // msg_vld is registered after the closing byte, so hold off one slot early
  assign q_full = (cnt_r == 2'd2) || (cnt_r != 2'd0 && msg_vld);

  // find the item for the current step and whether anything follows it
  function automatic logic present(input msg_t x, input logic [2:0] s);
    logic r;
    begin
      unique case (s)
        3'd0: r = 1'b1;
        3'd1: r = x.ok && x.pres[0];
        3'd2: r = x.ok && x.pres[1];
        3'd3: r = x.ok && x.pres[2];
        3'd4: r = x.ok && x.pres[3];
        3'd5: r = x.ok && x.cmd == CMD_SET;
        3'd6: r = x.ok && x.cmd == CMD_FIRE;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  logic [2:0] nstep;
  always_comb begin
    nstep = 3'd7;
    for (int s = 6; s >= 1; s--)
      if (3'(s) > step_r && present(m, 3'(s))) nstep = 3'(s);
    done = nstep == 3'd7;
    it = '0;
    it.kind = kind_t'(step_r);
    it.last = done;
    unique case (step_r)
      3'd0: begin it.ok = m.ok; it.first = 40'(m.dev); it.second = 32'(m.fmt);
        it.third = 32'(m.cmd); end
      3'd1: it.first = m.tbytes;
      3'd2: begin it.count = m.cnt1; it.first = 40'(m.c0); it.second = m.c1;
        it.third = m.c2; end
      3'd3: begin it.count = m.cnt2; it.first = 40'(m.c3); it.second = m.c4;
        it.third = m.c5; end
      3'd4: begin it.count = m.cnt3; it.first = 40'(m.c6); it.second = m.c7;
        it.third = m.c8; end
      3'd5: begin it.first = 40'(m.ctrl[27:14]); it.second = 32'(m.ctrl[13:0]); end
      3'd6: it.first = 40'(m.macro);
      default: ;
    endcase
  end

  // output register
  logic  ovld_r;
  item_t oitem_r;
  logic  load;
  assign out_vld = ovld_r;
  assign out_item = oitem_r;
  assign load = have && (!ovld_r || out_take);
  assign take = load && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0; step_r <= '0; ovld_r <= 1'b0;
    end else begin
      if (msg_vld) wp_r <= !wp_r;
      if (take) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(msg_vld) - 2'(take);
      if (load) step_r <= done ? 3'd0 : nstep;
      if (load) ovld_r <= 1'b1;
      else if (out_take) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_vld) q_r[wp_r] <= msg;
    if (load) oitem_r <= it;
  end
endmodule

>>> hdl/show_control_message_parser.sv
// ----------------------------------------------------------------------------
// show_control_message_parser
// Show-control system-exclusive receiver with a decoupled item emitter.
// ----------------------------------------------------------------------------
// Input queue side: drive in_rx_byte with push; a byte is taken when push is
// high and full is low. Each taken byte updates the registered parse state.
// Result queue side: while empty is low the oldest item sits on out_*; pop
// takes it. A message closed by 0xF7 yields a header item then, if its ok
// bit is set, one item per field present, last_item marking the end. A
// snapshot registered at 0xF7 passes via the message queue to the output
// register. Throughput: one byte per cycle in while full is low, one item
// per cycle out, walked by the emitter from a two-entry message queue, while
// pop is high. full rises while both message slots are taken, and for one
// cycle while a snapshot lands with the other slot taken; it persists when
// the receiver stalls for long, and bytes are then held off.
// Reset clears the parser to idle and empties both queues.
// ----------------------------------------------------------------------------
`include "show_control_message_parser_assert.svh"
module show_control_message_parser import scp_pkg::*; #(
  parameter int CUE_VALUE_WIDTH = CUE_VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_item_kind,
  output logic        out_ok,
  output logic [1:0]  out_component_count,
  output logic [39:0] out_first_value,
  output logic [31:0] out_second_value,
  output logic [31:0] out_third_value,
  output logic        out_last_item
);
  logic  msg_vld, q_full, out_vld, acc;
  msg_t  msg;
  item_t item;

  assign full = q_full;
  assign acc = push && !full;

  scp_front #(.CUE_VALUE_WIDTH(CUE_VALUE_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .byte_vld(acc), .rx_byte(in_rx_byte),
    .msg_vld(msg_vld), .msg(msg)
  );

  scp_back u_back (
    .clk(clk), .rst_n(rst_n), .msg_vld(msg_vld), .msg(msg), .q_full(q_full),
    .out_vld(out_vld), .out_item(item), .out_take(pop && !empty)
  );

  assign empty = !out_vld;
  assign out_item_kind = item.kind;
  assign out_ok = item.ok;
  assign out_component_count = item.count;
  assign out_first_value = item.first;
  assign out_second_value = item.second;
  assign out_third_value = item.third;
  assign out_last_item = item.last;

  `SCP_ASSERT_IMP(a_ok_hdr, clk, rst_n, !empty && out_ok, out_item_kind == KIND_HEADER)
  `SCP_ASSERT_IMP(a_cnt_cue, clk, rst_n, !empty && out_component_count != 2'd0,
    out_item_kind == KIND_CUE_NUM || out_item_kind == KIND_CUE_LIST || out_item_kind == KIND_CUE_PATH)
  `SCP_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_first_value))
endmodule

>>> verif/show_control_message_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// show_control_message_parser_test
// Drives show-control system-exclusive byte streams into the parser (well-formed
// messages of every command with random content, plus noise, restarts and
// broken headers), predicts the item runs and checks each popped item.
// ----------------------------------------------------------------------------
module show_control_message_parser_test;
  import scp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SUB, PH_DEV, PH_SUB2, PH_FMT, PH_CMD, PH_T0, PH_T1, PH_T2, PH_T3,
    PH_T4, PH_SET0, PH_SET1, PH_SET2, PH_SET3, PH_SETOPT, PH_FIRE, PH_OPTLIST,
    PH_CUE, PH_DONE
  } phase_t;

  class item_scoreboard;
    item_t       pending[$];
    int          mismatches;
    phase_t      phase;
    logic [7:0]  dev, fmt, cmd;
    logic [39:0] tbytes;
    logic [31:0] comp[9];
    logic [1:0]  cnt[3];
    logic [3:0]  pres;
    logic [13:0] ctl_num, ctl_val;
    logic [7:0]  macro;
    bit          err, cue_req, fopen, skip;
    int          cue_base, cue_max, begun;

    function void clear();
      dev = 0; fmt = 0; cmd = 0; tbytes = 0; pres = 0; ctl_num = 0; ctl_val = 0;
      macro = 0; err = 0; cue_base = 0; cue_max = 0; begun = 0;
      cue_req = 0; fopen = 0; skip = 0;
      foreach (comp[i]) comp[i] = 0;
      foreach (cnt[i]) cnt[i] = 0;
    endfunction

    function void open_cue(int base, int maxf, bit req);
      cue_base = base; cue_max = maxf; cue_req = req;
      begun = 0; fopen = 0; skip = 0; phase = PH_CUE;
    endfunction

    function void cue_text(logic [7:0] b);
      int slot, idx;
      if (!fopen) begin
        if (b == BYTE_NUL && begun > 0) return;
        if (begun >= cue_max) begin phase = PH_DONE; return; end
        slot = cue_base + begun;
        if (slot < 1 || slot > 3) begin phase = PH_DONE; return; end
        begun++; fopen = 1; skip = 0;
        cnt[slot-1] = 1; pres[slot] = 1'b1;
      end
      slot = cue_base + begun - 1;
      if (b == BYTE_NUL) begin fopen = 0; return; end
      if (skip) return;
      if (b == BYTE_DOT) begin
        if (cnt[slot-1] < 3) cnt[slot-1]++; else skip = 1;
        return;
      end
      if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
        idx = (slot - 1) * 3 + cnt[slot-1] - 1;
        comp[idx] = comp[idx] * 32'd10 + 32'(b - BYTE_ZERO);
      end
    endfunction

    function void decode_command(logic [7:0] c);
      case (c)
        8'h01, 8'h02, 8'h03, 8'h05, 8'h0B, 8'h10: open_cue(1, 3, 0);
        CMD_TIMED_GO, CMD_GO_LIGHT: phase = PH_T0;
        CMD_SET: phase = PH_SET0;
        CMD_FIRE: phase = PH_FIRE;
        8'h08, 8'h09, 8'h0A: phase = PH_DONE;
        8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h19, 8'h1A:
          phase = PH_OPTLIST;
        8'h1B, 8'h1C: open_cue(2, 1, 1);
        8'h1D, 8'h1E: open_cue(3, 1, 1);
        default: begin err = 1; phase = PH_DONE; end
      endcase
    endfunction

    function void add(kind_t k, logic [1:0] c, logic [39:0] a, logic [31:0] s,
                      logic [31:0] t);
      item_t it;
      it.kind = k; it.ok = 0; it.count = c; it.first = a;
      it.second = s; it.third = t; it.last = 0;
      pending.push_back(it);
    endfunction

    function void close_message();
      bit ok;
      item_t h;
      ok = !err;
      if (phase < PH_T0 || (phase >= PH_T0 && phase <= PH_SET3) || phase == PH_FIRE)
        ok = 0;
      if (phase == PH_CUE && cue_req && begun == 0) ok = 0;
      h.kind = KIND_HEADER; h.ok = ok; h.count = 0; h.first = 40'(dev);
      h.second = 32'(fmt); h.third = 32'(cmd); h.last = 0;
      pending.push_back(h);
      if (ok) begin
        if (pres[0]) add(KIND_TIME, 0, tbytes, 0, 0);
        for (int s = 1; s <= 3; s++)
          if (pres[s]) add(kind_t'(1 + s), cnt[s-1], 40'(comp[(s-1)*3]),
                           comp[(s-1)*3+1], comp[(s-1)*3+2]);
        if (cmd == CMD_SET) add(KIND_CONTROL, 0, 40'(ctl_num), 32'(ctl_val), 0);
        if (cmd == CMD_FIRE) add(KIND_MACRO, 0, 40'(macro), 0, 0);
      end
      pending[pending.size()-1].last = 1;
      phase = PH_IDLE;
    endfunction

    // one accepted input byte
    function void note_byte(logic [7:0] b);
      int i;
      if (b == BYTE_SOX) begin clear(); phase = PH_SUB; return; end
      if (b == BYTE_EOX) begin
        if (phase != PH_IDLE) close_message();
        return;
      end
      case (phase)
        PH_SUB: if (b != BYTE_SUB) begin err = 1; phase = PH_DONE; end
                else phase = PH_DEV;
        PH_DEV: begin dev = b; phase = PH_SUB2; end
        PH_SUB2: if (b != BYTE_MSC) begin err = 1; phase = PH_DONE; end
                 else phase = PH_FMT;
        PH_FMT: begin fmt = b; phase = PH_CMD; end
        PH_CMD: begin cmd = b; decode_command(b); end
        PH_SETOPT, PH_T0, PH_T1, PH_T2, PH_T3, PH_T4: begin
          i = (phase == PH_SETOPT) ? 0 : int'(phase) - int'(PH_T0);
          tbytes = tbytes | (40'(b) << ((4 - i) * 8));
          if (i < 4) phase = phase_t'(int'(PH_T0) + i + 1);
          else begin
            pres[0] = 1'b1;
            if (cmd == CMD_TIMED_GO) open_cue(1, 3, 0);
            else if (cmd == CMD_GO_LIGHT) phase = PH_OPTLIST;
            else phase = PH_DONE;
          end
        end
        PH_SET0: begin ctl_num[6:0] = b[6:0]; phase = PH_SET1; end
        PH_SET1: begin ctl_num[13:7] = b[6:0]; phase = PH_SET2; end
        PH_SET2: begin ctl_val[6:0] = b[6:0]; phase = PH_SET3; end
        PH_SET3: begin ctl_val[13:7] = b[6:0]; phase = PH_SETOPT; end
        PH_FIRE: begin macro = b; phase = PH_DONE; end
        PH_OPTLIST: if (b == BYTE_NUL) phase = PH_DONE;
                    else begin open_cue(2, 1, 0); cue_text(b); end
        PH_CUE: cue_text(b);
        default: ;
      endcase
    endfunction

    function void check_item(item_t got);
      item_t exp_it;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected item %p", got);
        return;
      end
      exp_it = pending.pop_front();
      if (got !== exp_it) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: item mismatch\n  expected %p\n  actual   %p", exp_it, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        push = 0;
  logic        pop = 0;
  logic [7:0]  in_rx_byte = 0;
  logic        full, empty;
  logic [2:0]  out_item_kind;
  logic        out_ok, out_last_item;
  logic [1:0]  out_component_count;
  logic [39:0] out_first_value;
  logic [31:0] out_second_value, out_third_value;

  item_scoreboard sb;
  logic [7:0] msg_bytes[$];
  bit rx_hold = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;

  always #5 clk = ~clk;

  show_control_message_parser dut (.*);

  // result side: pop with random gaps, long hold when requested
  initial begin
    item_t got;
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        pop <= 0;
        continue;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      got.kind = kind_t'(out_item_kind); got.ok = out_ok;
      got.count = out_component_count; got.first = out_first_value;
      got.second = out_second_value; got.third = out_third_value;
      got.last = out_last_item;
      sb.check_item(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, int gap);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(negedge clk);
    end
    in_rx_byte <= b;
    push <= 1;
    do @(posedge clk); while (full);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream(bit burst);
    int g;
    foreach (msg_bytes[i]) begin
      g = (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      send_byte(msg_bytes[i], g);
    end
    push <= 0;
    msg_bytes.delete();
    @(negedge clk);
  endtask

  task automatic add_header(logic [7:0] cmd);
    msg_bytes.push_back(BYTE_SOX);
    msg_bytes.push_back(BYTE_SUB);
    msg_bytes.push_back(8'($urandom_range(0, 255)));
    msg_bytes.push_back(BYTE_MSC);
    msg_bytes.push_back(8'($urandom_range(0, 255)));
    msg_bytes.push_back(cmd);
  endtask

  // dotted decimal cue field with up to five components
  task automatic add_cue_text();
    int n;
    n = $urandom_range(1, 5);
    for (int c = 0; c < n; c++) begin
      if (c > 0) msg_bytes.push_back(BYTE_DOT);
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 9) == 0) msg_bytes.push_back(8'($urandom_range(0, 255)));
        else msg_bytes.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
      end
    end
  endtask

  task automatic add_random_message();
    logic [7:0] cmds[$] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
      8'h09, 8'h0A, 8'h0B, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
      8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E};
    logic [7:0] cmd;
    int body, nf;
    cmd = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                       : cmds[$urandom_range(0, cmds.size() - 1)];
    add_header(cmd);
    if (cmd == CMD_SET) repeat (4) msg_bytes.push_back(8'($urandom_range(0, 255)));
    if (cmd == CMD_FIRE || cmd == CMD_SET || cmd == CMD_TIMED_GO || cmd == CMD_GO_LIGHT)
      if ($urandom_range(0, 1)) repeat (5) msg_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) msg_bytes.push_back(BYTE_NUL);
    nf = $urandom_range(0, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) repeat ($urandom_range(1, 2)) msg_bytes.push_back(BYTE_NUL);
      add_cue_text();
    end
    // occasional breakage: truncation, bad header byte, restart
    case ($urandom_range(0, 11))
      0: begin
        body = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > body) void'(msg_bytes.pop_back());
      end
      1: msg_bytes[$urandom_range(1, 1) + 2 * $urandom_range(0, 1)] =
           8'($urandom_range(0, 255));
      2: msg_bytes.push_back(BYTE_SOX);
      default: ;
    endcase
    msg_bytes.push_back(BYTE_EOX);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      msg_bytes.push_back(BYTE_EOX);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    int start_bytes;
    sb = new();
    sb.clear();
    sb.phase = PH_IDLE;
    sb.mismatches = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: idle bytes, stray end, each command family but 08-0A, edge values
    msg_bytes = '{8'h00, 8'hFF, BYTE_EOX, 8'h7F};
    send_stream(0);
    add_header(8'h01);
    msg_bytes = '{BYTE_SOX, BYTE_SUB, 8'hFF, BYTE_MSC, 8'hFF, 8'h01,
      8'h34, 8'h32, 8'h39, 8'h34, 8'h39, 8'h36, 8'h37, 8'h32, 8'h39, 8'h36, 8'h39,
      BYTE_DOT, 8'h35, BYTE_DOT, BYTE_DOT, 8'h37, 8'h00, 8'h00, 8'h31, 8'h00,
      8'h32, BYTE_EOX};
    send_stream(0);
    msg_bytes = '{BYTE_SOX, BYTE_SUB, 8'h00, BYTE_MSC, 8'h00, CMD_TIMED_GO,
      8'hFF, 8'h80, 8'h7F, 8'h01, 8'h00, 8'h39, BYTE_EOX};
    send_stream(0);
    msg_bytes = '{BYTE_SOX, BYTE_SUB, 8'h12, BYTE_MSC, 8'h01, CMD_SET,
      8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hAA, 8'h55, BYTE_EOX};
    send_stream(0);
    msg_bytes = '{BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, CMD_FIRE, 8'hFF, BYTE_EOX,
      BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, CMD_SET, 8'h01, BYTE_EOX,
      BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, 8'h1B, BYTE_EOX,
      BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, 8'h1D, 8'h00, 8'h33, BYTE_EOX,
      BYTE_SOX, 8'h7E, BYTE_EOX, BYTE_SOX, BYTE_SUB, 8'h01, 8'h03, BYTE_EOX,
      BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, 8'h00, BYTE_EOX,
      BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, 8'h11, 8'h00, 8'h35, BYTE_EOX,
      BYTE_SOX, BYTE_SUB, 8'h01, BYTE_MSC, 8'h01, CMD_GO_LIGHT, 1, 2, 3, 4, 5,
      8'h38, BYTE_SOX, BYTE_SUB, BYTE_EOX};
    send_stream(0);
    drain();

    // sender pauses until all results are in, then bursts against a held receiver
    rx_hold = 1;
    for (int m = 0; m < 6; m++) add_random_message();
    fork
      send_stream(1);
      begin
        repeat (300) @(negedge clk);
        rx_hold = 0;
      end
    join

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 30) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        if (msg_bytes[0] == BYTE_SOX) msg_bytes[0] = 8'h00;
      end
      add_random_message();
      send_stream(0);
      if ($urandom_range(0, 19) == 0) drain();
    end

    push <= 0;
    drain();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
